### src/lprl_pkg.sv
// ----------------------------------------------------------------------------
// lprl_pkg
// Shared types and constants of the longest-prefix route lookup block.
// ----------------------------------------------------------------------------
package lprl_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IFACE_BITS  = 4;

	localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STS_HIT     = 3'd0,
		STS_MISS    = 3'd1,
		STS_ADDED   = 3'd2,
		STS_FULL    = 3'd3,
		STS_CLEARED = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0]           dest;
		logic [31:0]           gateway;
		logic [31:0]           mask;
		logic [IFACE_BITS-1:0] iface;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

endpackage

### src/lprl_req_if.sv
// ----------------------------------------------------------------------------
// lprl_req_if
// Request channel: one table operation with its address and route fields.
// ----------------------------------------------------------------------------
interface lprl_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      op;
	logic [31:0]                     lookup_addr;
	logic [31:0]                     entry_dest;
	logic [31:0]                     entry_gateway;
	logic [31:0]                     entry_mask;
	logic [lprl_pkg::IFACE_BITS-1:0] entry_iface;

	modport source (
		output valid, op, lookup_addr, entry_dest, entry_gateway, entry_mask, entry_iface,
		input  ready
	);

	modport sink (
		input  valid, op, lookup_addr, entry_dest, entry_gateway, entry_mask, entry_iface,
		output ready
	);
endinterface

### src/lprl_rsp_if.sv
// ----------------------------------------------------------------------------
// lprl_rsp_if
// Response channel: status and the selected route of one request.
// ----------------------------------------------------------------------------
interface lprl_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      status;
	logic [31:0]                     route_gateway;
	logic [31:0]                     route_mask;
	logic [lprl_pkg::IFACE_BITS-1:0] route_iface;

	modport source (
		output valid, status, route_gateway, route_mask, route_iface,
		input  ready
	);

	modport sink (
		input  valid, status, route_gateway, route_mask, route_iface,
		output ready
	);
endinterface

### src/lprl_ram.sv
// ----------------------------------------------------------------------------
// lprl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lprl_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/longest_prefix_route_lookup_top.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_top
// IPv4 routing table with append, clear and longest-prefix lookup.
// ----------------------------------------------------------------------------
// Routes live in one single-port-read RAM and are appended in order, so the
// fill count alone tells which slots are valid. A lookup reads slots 0 to
// fill_count-1, one per cycle, through a single masked compare unit that
// keeps the best match so far (largest mask, earliest slot on ties); on an
// empty table it skips the scan and goes straight to the done state.
// Add, clear and unused operations go straight to the done state as well.
// A response register parts the two sides, so the next request is taken
// while a result waits, and only one request is in work at a time. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_top (
	input  logic       clk,
	input  logic       arst_n,
	lprl_req_if.sink   req,
	lprl_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                            state_q;
	logic [lprl_pkg::CNT_BITS-1:0]     fill_q;
	logic [lprl_pkg::ADDR_BITS-1:0]    idx_q;
	logic                              rd_vld_s1;
	logic                              is_lookup_q;
	lprl_pkg::status_t                 pend_status_q;
	logic                              found_q;
	logic [31:0]                       addr_q;
	logic [31:0]                       best_gw_q;
	logic [31:0]                       best_mask_q;
	logic [lprl_pkg::IFACE_BITS-1:0]   best_iface_q;

	logic                              rsp_vld_q;
	lprl_pkg::status_t                 rsp_status_q;
	logic [31:0]                       rsp_gw_q;
	logic [31:0]                       rsp_mask_q;
	logic [lprl_pkg::IFACE_BITS-1:0]   rsp_iface_q;

	logic                              accept;
	logic                              full;
	logic                              wr_en;
	logic                              rd_en;
	logic                              scan_last;
	logic                              rsp_load;
	logic                              match;
	logic                              better;
	lprl_pkg::entry_t                  wr_entry;
	lprl_pkg::entry_t                  rd_entry;
	logic [lprl_pkg::ENTRY_BITS-1:0]   rd_data;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (fill_q == lprl_pkg::CNT_BITS'(lprl_pkg::TABLE_DEPTH));
	assign wr_en     = accept && (req.op == lprl_pkg::OP_ADD) && !full;
	assign rd_en     = (state_q == ST_SCAN);
	assign scan_last = ((lprl_pkg::CNT_BITS'(idx_q) + lprl_pkg::CNT_BITS'(1)) == fill_q);
	assign rsp_load  = (state_q == ST_DONE) && !rd_vld_s1 && (!rsp_vld_q || rsp.ready);

	assign wr_entry.dest    = req.entry_dest;
	assign wr_entry.gateway = req.entry_gateway;
	assign wr_entry.mask    = req.entry_mask;
	assign wr_entry.iface   = req.entry_iface;

	lprl_ram #(
		.WIDTH (lprl_pkg::ENTRY_BITS),
		.DEPTH (lprl_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q[lprl_pkg::ADDR_BITS-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// Shared compare unit: one slot per cycle against the running best.
	assign rd_entry = lprl_pkg::entry_t'(rd_data);
	assign match    = (((addr_q ^ rd_entry.dest) & rd_entry.mask) == 32'd0);
	assign better   = !found_q || (rd_entry.mask > best_mask_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_vld_s1 && match && better) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						case (req.op)
							lprl_pkg::OP_ADD: begin
								if (!full) begin
									fill_q <= fill_q + lprl_pkg::CNT_BITS'(1);
								end
								state_q <= ST_DONE;
							end
							lprl_pkg::OP_CLEAR: begin
								fill_q  <= '0;
								state_q <= ST_DONE;
							end
							lprl_pkg::OP_LOOKUP: begin
								state_q <= (fill_q == '0) ? ST_DONE : ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + lprl_pkg::ADDR_BITS'(1);
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q       <= req.lookup_addr;
			is_lookup_q  <= (req.op == lprl_pkg::OP_LOOKUP);
			best_gw_q    <= '0;
			best_mask_q  <= '0;
			best_iface_q <= '0;
			case (req.op)
				lprl_pkg::OP_ADD:   pend_status_q <= full ? lprl_pkg::STS_FULL
				                                          : lprl_pkg::STS_ADDED;
				lprl_pkg::OP_CLEAR: pend_status_q <= lprl_pkg::STS_CLEARED;
				default:            pend_status_q <= lprl_pkg::STS_MISS;
			endcase
		end else if (rd_vld_s1 && match && better) begin
			best_gw_q    <= rd_entry.gateway;
			best_mask_q  <= rd_entry.mask;
			best_iface_q <= rd_entry.iface;
		end
		if (rsp_load) begin
			rsp_gw_q    <= best_gw_q;
			rsp_mask_q  <= best_mask_q;
			rsp_iface_q <= best_iface_q;
			if (is_lookup_q) begin
				rsp_status_q <= found_q ? lprl_pkg::STS_HIT : lprl_pkg::STS_MISS;
			end else begin
				rsp_status_q <= pend_status_q;
			end
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.route_gateway = rsp_gw_q;
	assign rsp.route_mask    = rsp_mask_q;
	assign rsp.route_iface   = rsp_iface_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lprl_pkg::CNT_BITS'(lprl_pkg::TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (fill_q < lprl_pkg::CNT_BITS'(lprl_pkg::TABLE_DEPTH)))
		else $error("route write into a full table");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (lprl_pkg::CNT_BITS'(idx_q) < fill_q))
		else $error("scan reads beyond the filled slots");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q != ST_IDLE))
		else $error("read data in flight while idle");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside the done state");

endmodule
